// ===== design/ptt_pkg.sv =====
// Shared types and constants for the page temperature table.
// Command codes, register indexes, field widths and the match status struct.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 64;

  localparam int unsigned PAGE_W   = 36;
  localparam int unsigned AMOUNT_W = 8;
  localparam int unsigned RAND_W   = 32;
  localparam int unsigned TEMP_W   = 5;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // in_tdata: 79 field bits padded to 80
  localparam int unsigned IN_DATA_W  = 80;
  // out_tdata: 10 field bits padded to 16
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ABORT = 3'd0,
    CMD_INCR  = 3'd1,
    CMD_RESET = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_TICK  = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WARM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 2'd3;

  localparam logic [LEVEL_W-1:0] LVL_COLD = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARM = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HOT  = 2'd2;

  localparam logic [TEMP_W-1:0] WARM_RESET  = 5'd5;
  localparam logic [TEMP_W-1:0] HOT_RESET   = 5'd10;
  localparam logic [TEMP_W-1:0] MAX_RESET   = 5'd10;
  localparam logic [TICK_W-1:0] DECAY_RESET = 32'd1000;

  typedef struct packed {
    logic hit;
    logic full;
  } cam_status_t;

endpackage

`default_nettype wire

// ===== design/ptt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/ptt_cam.sv =====
// Page tag store: associative match of one page against all valid entries,
// fill-count allocation and bulk invalidate. Uses ptt_pkg.
`default_nettype none

module ptt_cam #(
  parameter int unsigned ENTRIES = ptt_pkg::DEF_TABLE_ENTRIES,
  localparam int unsigned IW = $clog2(ENTRIES),
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ptt_pkg::PAGE_W-1:0]  lookup_page,
  input  wire logic                        alloc,
  input  wire logic                        clear,
  output logic      [IW-1:0]               slot,
  output ptt_pkg::cam_status_t             status
);

  import ptt_pkg::*;

  logic [PAGE_W-1:0]  tag_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      match_idx;
  logic               hit;

  // tags are unique, so the match vector is one-hot: OR the indexes together
  always_comb begin
    match_idx = '0;
    hit       = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && tag_r[i] == lookup_page) begin
        hit       = 1'b1;
        match_idx = match_idx | IW'(i);
      end
    end
  end

  // entries only free all at once, so valid entries are always a prefix
  assign status.hit  = hit;
  assign status.full = (count_r == CW'(ENTRIES));
  assign slot        = hit ? match_idx : count_r[IW-1:0];

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (clear) begin
      valid_nxt = '0;
      count_nxt = '0;
    end else if (alloc) begin
      valid_nxt[count_r[IW-1:0]] = 1'b1;
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc && !clear) begin
      tag_r[count_r[IW-1:0]] <= lookup_page;
    end
  end

endmodule

`default_nettype wire

// ===== design/page_temperature_table.sv =====
// Page temperature table, top level.
// An accepted item passes a lookup state (tag match, temperature RAM read) and an
// execute state (update) that sets out_tvalid; no new item is taken in between;
//   the update waits while the previous result is still held in the output register.
// Reset: synchronous; all entries invalid, all temperatures cold through per-entry
//   flags, tick counter zero, registers at their defaults; no clearing pass.
`default_nettype none

module page_temperature_table #(
  parameter int unsigned TABLE_ENTRIES = ptt_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command[2:0], page_number[38:3], increment_amount[46:39],
  // random_bits[78:47], zero[79]
  input  wire logic [ptt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // temperature[4:0], level[6:5], page_present[7], table_full[8],
  // decayed[9], zero[15:10]
  output logic      [ptt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_we,
  input  wire logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import ptt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [TEMP_W-1:0] warm_r, hot_r, max_r;
  logic [TICK_W-1:0] interval_r;

  // captured item
  logic [CMD_W-1:0]    cmd_r;
  logic [PAGE_W-1:0]   page_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic [RAND_W-1:0]   rnd_r;

  // lookup results
  logic [IW-1:0] slot_r;
  logic          present_r;
  logic          full_r;

  logic [TICK_W-1:0]        ticks_r, ticks_nxt;
  logic [TABLE_ENTRIES-1:0] temp_ok_r, temp_ok_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              in_fire, exec_fire, is_add;
  logic              cam_alloc, cam_clear;
  logic [IW-1:0]     cam_slot;
  cam_status_t       cam_st;
  logic [TEMP_W-1:0] rd_temp, cur;

  logic              ram_we;
  logic [TEMP_W-1:0] ram_wdata;

  logic [RAND_W-1:0] top_mask;
  logic              bump;
  logic [TEMP_W:0]   abort_sum;
  logic [8:0]        incr_sum;
  logic [TEMP_W-1:0] upd_temp, res_temp;
  logic [TICK_W:0]   ticks_inc;
  logic              decay, res_present;
  logic [LEVEL_W-1:0] res_level;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign is_add    = (cmd_r == CMD_ABORT) || (cmd_r == CMD_INCR);
  assign cam_alloc = (state_r == ST_LOOK) && is_add && !cam_st.hit && !cam_st.full;
  assign cam_clear = exec_fire && (cmd_r == CMD_CLEAR);

  ptt_cam #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_cam (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_r),
    .alloc       (cam_alloc),
    .clear       (cam_clear),
    .slot        (cam_slot),
    .status      (cam_st)
  );

  ptt_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_temp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (state_r == ST_LOOK),
    .raddr (cam_slot),
    .rdata (rd_temp)
  );

  // an entry whose flag dropped reads as cold
  assign cur = temp_ok_r[slot_r] ? rd_temp : '0;

  // abort bumps at cur 0, or below max if the top cur bits of rnd_r are all zero
  assign top_mask  = ~({RAND_W{1'b1}} >> cur);
  assign bump      = (cur == '0) || ((cur < max_r) && ((rnd_r & top_mask) == '0));
  assign abort_sum = {1'b0, cur} + (TEMP_W + 1)'(bump);
  assign incr_sum  = 9'(cur) + 9'(amount_r);
  assign ticks_inc = {1'b0, ticks_r} + (TICK_W + 1)'(1);
  assign decay     = (ticks_inc >= {1'b0, interval_r});

  always_comb begin
    if (cmd_r == CMD_ABORT) begin
      if (abort_sum > {1'b0, max_r}) begin
        upd_temp = (cur > max_r) ? cur : max_r;
      end else begin
        upd_temp = abort_sum[TEMP_W-1:0];
      end
    end else if (incr_sum > 9'(max_r)) begin
      upd_temp = max_r;
    end else begin
      upd_temp = incr_sum[TEMP_W-1:0];
    end
  end

  assign ram_we    = exec_fire && is_add && present_r;
  assign ram_wdata = upd_temp;

  always_comb begin
    // an absent page always reports zero
    res_temp    = present_r ? cur : '0;
    res_present = present_r;
    ticks_nxt   = ticks_r;
    temp_ok_nxt = temp_ok_r;
    if (cam_alloc) begin
      temp_ok_nxt[cam_slot] = 1'b0;
    end
    if (exec_fire) begin
      case (cmd_r)
        CMD_ABORT, CMD_INCR: begin
          res_temp = present_r ? upd_temp : '0;
          if (present_r) begin
            temp_ok_nxt[slot_r] = 1'b1;
          end
        end
        CMD_RESET: begin
          res_temp = '0;
          if (present_r) begin
            temp_ok_nxt[slot_r] = 1'b0;
          end
        end
        CMD_TICK: begin
          if (decay) begin
            res_temp    = '0;
            ticks_nxt   = '0;
            temp_ok_nxt = '0;
          end else begin
            ticks_nxt = ticks_inc[TICK_W-1:0];
          end
        end
        CMD_CLEAR: begin
          res_temp    = '0;
          res_present = 1'b0;
          ticks_nxt   = '0;
          temp_ok_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (!res_present) begin
      res_level = LVL_COLD;
    end else if (res_temp >= hot_r) begin
      res_level = LVL_HOT;
    end else if (res_temp >= warm_r) begin
      res_level = LVL_WARM;
    end else begin
      res_level = LVL_COLD;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_EXEC;
      ST_EXEC: if (exec_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ticks_r     <= '0;
      temp_ok_r   <= '0;
      out_valid_r <= 1'b0;
      warm_r      <= WARM_RESET;
      hot_r       <= HOT_RESET;
      max_r       <= MAX_RESET;
      interval_r  <= DECAY_RESET;
    end else begin
      state_r   <= state_nxt;
      ticks_r   <= ticks_nxt;
      temp_ok_r <= temp_ok_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WARM:     warm_r     <= cfg_wdata[TEMP_W-1:0];
          CFG_HOT:      hot_r      <= cfg_wdata[TEMP_W-1:0];
          CFG_MAX_TEMP: max_r      <= cfg_wdata[TEMP_W-1:0];
          CFG_DECAY:    interval_r <= cfg_wdata[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_tdata[2:0];
      page_r   <= in_tdata[38:3];
      amount_r <= in_tdata[46:39];
      rnd_r    <= in_tdata[78:47];
    end
    if (state_r == ST_LOOK) begin
      slot_r    <= cam_slot;
      present_r <= cam_st.hit || cam_alloc;
      full_r    <= is_add && !cam_st.hit && cam_st.full;
    end
    if (exec_fire) begin
      out_data_r <= {6'd0, (cmd_r == CMD_TICK) && decay, full_r, res_present,
                     res_level, res_temp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
